[src/rpnr_pkg.sv]
// Shared types and constants of the ring packet node receiver.
package rpnr_pkg;

	localparam int MAX_PAYLOAD_DEF = 28;
	localparam int BYTE_W          = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int MAXP_W          = 5;
	localparam logic [BYTE_W-1:0] BCAST_ADDR = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_OWN_BC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_OWN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_FWD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 3'd4;

	typedef enum logic [3:0] {
		ST_DST,
		ST_SRC,
		ST_LEN,
		ST_DATA,
		ST_SKIP,
		ST_FIN,
		ST_EMPTY,
		ST_DLV,
		ST_RDST,
		ST_RSRC,
		ST_RLEN,
		ST_RPAY
	} state_t;

	typedef enum logic [2:0] {
		SEL_PAY,
		SEL_DST,
		SEL_SRC,
		SEL_LEN,
		SEL_EMPTY
	} emit_sel_t;

	typedef struct packed {
		logic      cap_dst;
		logic      cap_src;
		logic      cap_len;
		logic      store;
		logic      skip;
		logic      rd_clr;
		logic      rd_inc;
		logic      emit;
		logic      emit_port;
		emit_sel_t emit_sel;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic len_zero;
		logic data_last;
		logic skip_last;
		logic deliver;
		logic retx;
		logic fill_zero;
		logic rd_last;
		logic out_free;
	} sts_t;

endpackage

[src/rpnr_ctrl.sv]
// Controller state machine: frame parsing and sequencing of delivery and retransmit runs.
module rpnr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rpnr_pkg::sts_t sts,
	output rpnr_pkg::cmd_t cmd
);
	import rpnr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   acc;

	assign in_ready = (state_q inside {ST_DST, ST_SRC, ST_LEN, ST_DATA, ST_SKIP});
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DST;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.emit_sel = SEL_PAY;
		unique case (state_q)
			ST_DST: begin
				if (acc) begin
					cmd.cap_dst = 1'b1;
					state_d     = ST_SRC;
				end
			end
			ST_SRC: begin
				if (acc) begin
					cmd.cap_src = 1'b1;
					state_d     = ST_LEN;
				end
			end
			ST_LEN: begin
				if (acc) begin
					cmd.cap_len = 1'b1;
					if (sts.drop) begin
						state_d = sts.len_zero ? ST_DST : ST_SKIP;
					end else if (sts.len_zero) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (acc) begin
					cmd.store = 1'b1;
					if (sts.data_last) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SKIP: begin
				if (acc) begin
					cmd.skip = 1'b1;
					if (sts.skip_last) begin
						state_d = ST_DST;
					end
				end
			end
			ST_FIN: begin
				cmd.rd_clr = 1'b1;
				if (sts.deliver) begin
					state_d = sts.fill_zero ? ST_EMPTY : ST_DLV;
				end else if (sts.retx) begin
					state_d = ST_RDST;
				end else begin
					state_d = ST_DST;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = SEL_EMPTY;
					state_d      = ST_DST;
				end
			end
			ST_DLV: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.rd_inc = 1'b1;
					if (sts.rd_last) begin
						cmd.rd_clr = 1'b1;
						state_d    = sts.retx ? ST_RDST : ST_DST;
					end
				end
			end
			ST_RDST: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_port = 1'b1;
					cmd.emit_sel  = SEL_DST;
					state_d       = ST_RSRC;
				end
			end
			ST_RSRC: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_port = 1'b1;
					cmd.emit_sel  = SEL_SRC;
					state_d       = ST_RLEN;
				end
			end
			ST_RLEN: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_port = 1'b1;
					cmd.emit_sel  = SEL_LEN;
					state_d       = ST_RPAY;
				end
			end
			ST_RPAY: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_port = 1'b1;
					cmd.rd_inc    = 1'b1;
					if (sts.rd_last) begin
						state_d = ST_DST;
					end
				end
			end
			default: begin
				state_d = ST_DST;
			end
		endcase
	end

endmodule

[src/rpnr_dp.sv]
// Datapath: configuration, header and count registers, payload store and output register.
module rpnr_dp #(
	parameter int MAX_PAYLOAD = rpnr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rpnr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rpnr_pkg::BYTE_W-1:0]      cfg_wdata,
	input  logic [rpnr_pkg::BYTE_W-1:0]      rx_byte,
	input  rpnr_pkg::cmd_t                   cmd,
	output rpnr_pkg::sts_t                   sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             port,
	output logic [rpnr_pkg::BYTE_W-1:0]      frame_dst,
	output logic [rpnr_pkg::BYTE_W-1:0]      frame_src,
	output logic [rpnr_pkg::BYTE_W-1:0]      data_byte,
	output logic                             has_data,
	output logic                             end_of_run
);
	import rpnr_pkg::*;

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = $clog2((MAX_PAYLOAD > 1) ? MAX_PAYLOAD : 2);

	logic [BYTE_W-1:0] node_id_q;
	logic              read_own_bc_q;
	logic              read_own_q;
	logic              read_fwd_q;
	logic [MAXP_W-1:0] max_payload_q;

	logic [BYTE_W-1:0] dst_q;
	logic [BYTE_W-1:0] src_q;
	logic [BYTE_W-1:0] rem_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  rd_q;
	logic [BYTE_W-1:0] mem_q [MAX_PAYLOAD];
	logic [BYTE_W-1:0] rd_data_q;

	logic              out_valid_q;
	logic              port_q;
	logic [BYTE_W-1:0] out_dst_q;
	logic [BYTE_W-1:0] out_src_q;
	logic [BYTE_W-1:0] data_q;
	logic              has_q;
	logic              last_q;

	logic [BYTE_W-1:0] limit;
	logic              bc;
	logic              own;
	logic [CNT_W-1:0]  rd_nxt;
	logic [BYTE_W-1:0] emit_data;
	logic              emit_has;
	logic              emit_last;

	assign bc    = (dst_q == BCAST_ADDR);
	assign own   = (src_q == node_id_q);
	assign limit = (BYTE_W'(max_payload_q) > BYTE_W'(MAX_PAYLOAD)) ?
	               BYTE_W'(MAX_PAYLOAD) : BYTE_W'(max_payload_q);

	always_comb begin
		if (cmd.rd_clr) begin
			rd_nxt = '0;
		end else if (cmd.rd_inc) begin
			rd_nxt = rd_q + CNT_W'(1);
		end else begin
			rd_nxt = rd_q;
		end
	end

	assign sts.drop      = (own && ((bc && !read_own_bc_q) || !read_own_q)) || (rx_byte > limit);
	assign sts.len_zero  = (rx_byte == '0);
	assign sts.data_last = (rem_q == BYTE_W'(1));
	assign sts.skip_last = (rem_q <= BYTE_W'(1));
	assign sts.deliver   = bc || (dst_q == node_id_q) || read_fwd_q;
	assign sts.retx      = (fill_q != '0) && !own && (bc || (dst_q != node_id_q));
	assign sts.fill_zero = (fill_q == '0);
	assign sts.rd_last   = ((rd_q + CNT_W'(1)) == fill_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		emit_data = rd_data_q;
		emit_has  = 1'b1;
		emit_last = 1'b0;
		unique case (cmd.emit_sel)
			SEL_PAY: begin
				emit_last = sts.rd_last;
			end
			SEL_DST: begin
				emit_data = dst_q;
			end
			SEL_SRC: begin
				emit_data = src_q;
			end
			SEL_LEN: begin
				emit_data = BYTE_W'(fill_q);
			end
			SEL_EMPTY: begin
				emit_data = '0;
				emit_has  = 1'b0;
				emit_last = 1'b1;
			end
			default: begin
				emit_data = rd_data_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q     <= '0;
			read_own_bc_q <= 1'b0;
			read_own_q    <= 1'b0;
			read_fwd_q    <= 1'b0;
			max_payload_q <= MAXP_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_NODE_ID:     node_id_q     <= cfg_wdata;
				CFG_READ_OWN_BC: read_own_bc_q <= cfg_wdata[0];
				CFG_READ_OWN:    read_own_q    <= cfg_wdata[0];
				CFG_READ_FWD:    read_fwd_q    <= cfg_wdata[0];
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_wdata[MAXP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			fill_q      <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cap_len) begin
				rem_q  <= rx_byte;
				fill_q <= '0;
			end else if (cmd.store) begin
				rem_q  <= rem_q - BYTE_W'(1);
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.skip) begin
				rem_q <= rem_q - BYTE_W'(1);
			end
			rd_q <= rd_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_dst) begin
			dst_q <= rx_byte;
		end
		if (cmd.cap_src) begin
			src_q <= rx_byte;
		end
		if (cmd.store) begin
			mem_q[fill_q[IDX_W-1:0]] <= rx_byte;
		end
		rd_data_q <= mem_q[rd_nxt[IDX_W-1:0]];
		if (cmd.emit) begin
			port_q    <= cmd.emit_port;
			out_dst_q <= dst_q;
			out_src_q <= src_q;
			data_q    <= emit_data;
			has_q     <= emit_has;
			last_q    <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign port       = port_q;
	assign frame_dst  = out_dst_q;
	assign frame_src  = out_src_q;
	assign data_byte  = data_q;
	assign has_data   = has_q;
	assign end_of_run = last_q;

endmodule

[src/ring_packet_node_receiver.sv]
// Ring packet node receiver top level: controller and datapath.
// Receive bytes are taken one per cycle while the controller parses (in_ready high); after the
// last byte of a kept frame it holds the input through a decision state and the delivery and
// retransmit runs, so no new frame is taken until those are done; output stalls lengthen them.
// The first result item is loaded into the output register after the decision state.
// Reset clears the state machine, counters, output valid and configuration (max_payload 16).
module ring_packet_node_receiver #(
	parameter int MAX_PAYLOAD = rpnr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rpnr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rpnr_pkg::BYTE_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rpnr_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           port,
	output logic [rpnr_pkg::BYTE_W-1:0]    frame_dst,
	output logic [rpnr_pkg::BYTE_W-1:0]    frame_src,
	output logic [rpnr_pkg::BYTE_W-1:0]    data_byte,
	output logic                           has_data,
	output logic                           end_of_run
);
	import rpnr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rpnr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpnr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.port       (port),
		.frame_dst  (frame_dst),
		.frame_src  (frame_src),
		.data_byte  (data_byte),
		.has_data   (has_data),
		.end_of_run (end_of_run)
	);

endmodule

[tb/sv/ring_packet_node_receiver_tb.sv]
// Testbench for the ring packet node receiver: framed byte stimulus checked by a frame predictor.
module ring_packet_node_receiver_tb;
	import rpnr_pkg::*;

	localparam int QUIET_LIMIT      = 4000;
	localparam int SETTLE_CYCLES    = 64;
	localparam int KEPT_PER_SETTING = 16;
	localparam int NUM_SETTINGS     = 7;
	localparam logic PORT_LOCAL     = 1'b0;
	localparam logic PORT_RING      = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic  port;
		byte_t dst;
		byte_t src;
		byte_t data;
		logic  has;
		logic  last;
	} run_item_t;

	class ring_frame_tracker;
		byte_t             node_id;
		logic              read_own_bc;
		logic              read_own;
		logic              read_fwd;
		logic [MAXP_W-1:0] max_payload;
		state_t            ph;
		byte_t             hdr_dst;
		byte_t             hdr_src;
		byte_t             remaining;
		int                fill;
		byte_t             store [MAX_PAYLOAD_DEF];
		run_item_t         due_items [$];
		int                mismatches;
		int                matched;
		int                kept_bytes;
		int                local_runs;
		int                empty_runs;
		int                retx_runs;
		int                dropped;

		function new();
			node_id     = '0;
			read_own_bc = 1'b0;
			read_own    = 1'b0;
			read_fwd    = 1'b0;
			max_payload = 5'd16;
			ph          = ST_DST;
			hdr_dst     = '0;
			hdr_src     = '0;
			remaining   = '0;
			fill        = 0;
			mismatches  = 0;
			matched     = 0;
			kept_bytes  = 0;
			local_runs  = 0;
			empty_runs  = 0;
			retx_runs   = 0;
			dropped     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, byte_t v);
			case (idx)
				CFG_NODE_ID:     node_id = v;
				CFG_READ_OWN_BC: read_own_bc = v[0];
				CFG_READ_OWN:    read_own = v[0];
				CFG_READ_FWD:    read_fwd = v[0];
				CFG_MAX_PAYLOAD: max_payload = v[MAXP_W-1:0];
				default: ;
			endcase
		endfunction

		function int limit();
			return (max_payload > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(max_payload);
		endfunction

		function int pending();
			return due_items.size();
		endfunction

		function bit at_frame_start();
			return ph == ST_DST;
		endfunction

		function void push(logic p, byte_t d, logic h, logic l);
			run_item_t it;
			it.port = p;
			it.dst  = hdr_dst;
			it.src  = hdr_src;
			it.data = d;
			it.has  = h;
			it.last = l;
			due_items.push_back(it);
		endfunction

		function void complete();
			logic bc;
			bc = hdr_dst == BCAST_ADDR;
			ph = ST_DST;
			if (bc || hdr_dst == node_id || read_fwd) begin
				local_runs++;
				if (fill == 0) begin
					push(PORT_LOCAL, '0, 1'b0, 1'b1);
					empty_runs++;
				end else begin
					for (int i = 0; i < fill; i++)
						push(PORT_LOCAL, store[i], 1'b1, i + 1 == fill);
				end
			end
			if (fill != 0 && hdr_src != node_id && (bc || hdr_dst != node_id)) begin
				retx_runs++;
				push(PORT_RING, hdr_dst, 1'b1, 1'b0);
				push(PORT_RING, hdr_src, 1'b1, 1'b0);
				push(PORT_RING, byte_t'(fill), 1'b1, 1'b0);
				for (int i = 0; i < fill; i++)
					push(PORT_RING, store[i], 1'b1, i + 1 == fill);
			end
			fill = 0;
		endfunction

		function void take_byte(byte_t b);
			logic drop;
			if (ph != ST_SKIP)
				kept_bytes++;
			case (ph)
				ST_DST: begin
					hdr_dst = b;
					ph = ST_SRC;
				end
				ST_SRC: begin
					hdr_src = b;
					ph = ST_LEN;
				end
				ST_LEN: begin
					remaining = b;
					fill = 0;
					drop = 1'b0;
					if (hdr_src == node_id) begin
						if (hdr_dst == BCAST_ADDR && !read_own_bc)
							drop = 1'b1;
						else if (!read_own)
							drop = 1'b1;
					end
					if (int'(remaining) > limit())
						drop = 1'b1;
					if (drop) begin
						dropped++;
						ph = (remaining != 0) ? ST_SKIP : ST_DST;
					end else if (remaining == 0) begin
						complete();
					end else begin
						ph = ST_DATA;
					end
				end
				ST_DATA: begin
					if (fill < MAX_PAYLOAD_DEF)
						store[fill] = b;
					fill++;
					remaining--;
					if (remaining == 0 || fill >= MAX_PAYLOAD_DEF)
						complete();
				end
				ST_SKIP: begin
					if (remaining != 0)
						remaining--;
					if (remaining == 0)
						ph = ST_DST;
				end
				default: ph = ST_DST;
			endcase
		endfunction

		function void compare(string name, int want, int seen);
			if (want != seen) begin
				$error("%s: expected %0h, got %0h", name, want, seen);
				mismatches++;
			end
		endfunction

		function void match_output(run_item_t got);
			run_item_t want;
			if (due_items.size() == 0) begin
				$error("unexpected item: port %0d dst %0h src %0h data %0h has %0d last %0d",
					got.port, got.dst, got.src, got.data, got.has, got.last);
				mismatches++;
				return;
			end
			want = due_items.pop_front();
			matched++;
			compare("port", want.port, got.port);
			compare("frame_dst", want.dst, got.dst);
			compare("frame_src", want.src, got.src);
			compare("data_byte", want.data, got.data);
			compare("has_data", want.has, got.has);
			compare("end_of_run", want.last, got.last);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	byte_t                cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	byte_t                rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 port;
	byte_t                frame_dst;
	byte_t                frame_src;
	byte_t                data_byte;
	logic                 has_data;
	logic                 end_of_run;

	ring_frame_tracker tracker = new();
	int quiet_cycles = 0;
	int burst_left = 0;
	int bytes_sent = 0;
	int settings_run = 0;
	int stall_mode = 0;
	int stall_span = 0;

	ring_packet_node_receiver dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(8, 64);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_output(run_item_t'{port, frame_dst, frame_src, data_byte,
				has_data, end_of_run});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("ring_packet_node_receiver verification failed");
		$finish;
	end

	task automatic send_byte(input byte_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input byte_t dst, input byte_t src, input byte_t len,
			input int nbytes);
		send_byte(dst);
		send_byte(src);
		send_byte(len);
		repeat (nbytes)
			send_byte(byte_t'($urandom));
	endtask

	task automatic send_random_frame();
		int    lim;
		int    pick;
		int    len;
		byte_t dst;
		byte_t src;
		lim = tracker.limit();
		// misalign the framing now and then
		if ($urandom_range(0, 19) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(byte_t'($urandom));
		pick = $urandom_range(0, 9);
		dst = (pick < 3) ? BCAST_ADDR : (pick < 6) ? tracker.node_id : byte_t'($urandom);
		src = ($urandom_range(0, 3) == 0) ? tracker.node_id : byte_t'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 7)
			len = $urandom_range(0, lim);
		else if (pick < 8)
			len = 0;
		else
			len = lim + $urandom_range(1, 4);
		send_frame(dst, src, byte_t'(len), len);
	endtask

	task automatic drain_outputs();
		in_valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		tracker.set_reg(idx, v);
	endtask

	task automatic program_setting(input byte_t node, input logic own_bc, input logic own,
			input logic fwd, input logic [MAXP_W-1:0] maxp);
		write_reg(CFG_NODE_ID, node);
		write_reg(CFG_READ_OWN_BC, {7'b0, own_bc});
		write_reg(CFG_READ_OWN, {7'b0, own});
		write_reg(CFG_READ_FWD, {7'b0, fwd});
		write_reg(CFG_MAX_PAYLOAD, byte_t'(maxp));
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	initial begin
		int first_kept;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_frame(8'h00, 8'h05, 8'd0, 0);
		send_frame(BCAST_ADDR, 8'h00, 8'd0, 0);
		send_frame(8'h07, 8'h09, 8'd2, 2);
		send_frame(BCAST_ADDR, 8'h03, 8'd1, 1);
		send_frame(8'h01, 8'h02, 8'd17, 17);
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			if (s != 0) begin
				drain_outputs();
				case (s)
					1: begin
						program_setting(8'hFF, 1'b1, 1'b1, 1'b1, 5'd31);
						send_frame(BCAST_ADDR, 8'hFF, 8'd0, 0);
						send_frame(8'h80, 8'hFF, 8'd1, 1);
						send_frame(8'h12, 8'h34, 8'd28, 28);
						send_frame(8'h12, 8'h34, 8'd29, 29);
					end
					2: begin
						program_setting(8'h00, 1'b0, 1'b0, 1'b0, 5'd0);
						send_frame(8'h05, 8'h06, 8'd0, 0);
						send_frame(8'h00, 8'h00, 8'd0, 0);
						send_frame(8'h03, 8'h04, 8'd20, 20);
					end
					3: begin
						program_setting(8'hFE, 1'b1, 1'b0, 1'b0, 5'd28);
						send_frame(BCAST_ADDR, 8'hFE, 8'd2, 2);
						send_frame(8'hFE, 8'h01, 8'd2, 2);
					end
					default: program_setting(byte_t'($urandom_range(0, 254)), 1'($urandom),
						1'($urandom), 1'($urandom), 5'($urandom));
				endcase
			end
			first_kept = tracker.kept_bytes;
			while (tracker.kept_bytes - first_kept < KEPT_PER_SETTING)
				send_random_frame();
			// finish any frame left open
			while (!tracker.at_frame_start())
				send_byte(byte_t'($urandom));
		end
		drain_outputs();
		$display("%0d bytes sent under %0d register settings, %0d result items checked",
			bytes_sent, settings_run + 1, tracker.matched);
		$display("%0d local runs (%0d empty), %0d retransmit runs, %0d frames dropped",
			tracker.local_runs, tracker.empty_runs, tracker.retx_runs, tracker.dropped);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("ring_packet_node_receiver verification clean");
		else
			$display("ring_packet_node_receiver verification failed");
		$finish;
	end

endmodule
